### hdl/nss_pkg.sv
// shared types, constants and helpers for the nmea sentence selector
`timescale 1ns / 1ps

package nss_pkg;

   // character codes
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_START = 8'h24;
   localparam logic [7:0] CHAR_SEP   = 8'h2C;

   // length of the wanted sentence name
   localparam logic [4:0] MATCH_LEN = 5'd5;

   // result kinds
   localparam logic [1:0] KIND_BODY  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_INTERVAL    = 2'd0;
   localparam logic [1:0] CSR_FIELD_LIMIT = 2'd1;
   localparam logic [1:0] CSR_NAME_LIMIT  = 2'd2;

   // register reset values
   localparam logic [7:0] INTERVAL_RESET    = 8'd5;
   localparam logic [7:0] FIELD_LIMIT_RESET = 8'd100;
   localparam logic [4:0] NAME_LIMIT_RESET  = 5'd20;

   typedef struct packed {
      logic [7:0] interval;
      logic [7:0] field_limit;
      logic [4:0] name_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] body_byte;
   } rsp_type;

   // expected character of the wanted name at a position below MATCH_LEN
   function automatic logic [7:0] wanted_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:    c = "G";
         5'd1:    c = "P";
         5'd2:    c = "R";
         5'd3:    c = "M";
         5'd4:    c = "C";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### hdl/nss_parser.sv
// sentence structure tracker: parse state and per-byte result logic
`timescale 1ns / 1ps

module nss_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  nss_pkg::cfg_type cfg,
   output logic             has_result,
   output nss_pkg::rsp_type result
);
   import nss_pkg::*;

   logic       after_newline_ff, after_newline_in;
   logic       in_name_ff, in_name_in;
   logic       capturing_ff, capturing_in;
   logic [4:0] name_length_ff, name_length_in;
   logic       name_matches_ff, name_matches_in;
   logic [7:0] sentence_phase_ff, sentence_phase_in;
   logic [7:0] body_length_ff, body_length_in;

   logic [7:0] body_next;
   logic [4:0] name_next;
   logic [7:0] phase_next;

   assign body_next  = body_length_ff + 8'd1;
   assign name_next  = name_length_ff + 5'd1;
   assign phase_next = sentence_phase_ff + 8'd1;

   // next state and result for the byte in the input stage
   always_comb begin
      after_newline_in  = after_newline_ff;
      in_name_in        = in_name_ff;
      capturing_in      = capturing_ff;
      name_length_in    = name_length_ff;
      name_matches_in   = name_matches_ff;
      sentence_phase_in = sentence_phase_ff;
      body_length_in    = body_length_ff;
      has_result        = 1'b0;
      result.kind       = KIND_BODY;
      result.body_byte  = 8'h00;

      if (capturing_ff) begin
         has_result = 1'b1;
         if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
            capturing_in = 1'b0;
            result.kind  = KIND_END;
            if (rx_byte == CHAR_LF) begin
               after_newline_in = 1'b1;
               in_name_in       = 1'b0;
            end
         end else if (body_next == cfg.field_limit) begin
            capturing_in   = 1'b0;
            body_length_in = 8'd0;
            result.kind    = KIND_ABORT;
         end else begin
            body_length_in   = body_next;
            result.body_byte = rx_byte;
         end
      end else if (rx_byte == CHAR_LF) begin
         after_newline_in = 1'b1;
         in_name_in       = 1'b0;
      end else if (after_newline_ff) begin
         if (rx_byte == CHAR_START) begin
            in_name_in      = 1'b1;
            name_length_in  = 5'd0;
            name_matches_in = 1'b1;
         end
         after_newline_in = 1'b0;
      end else if (in_name_ff) begin
         if (rx_byte == CHAR_SEP) begin
            in_name_in = 1'b0;
            if (name_matches_ff && name_length_ff == MATCH_LEN) begin
               if (sentence_phase_ff == 8'd0) begin
                  capturing_in   = 1'b1;
                  body_length_in = 8'd0;
               end
               sentence_phase_in = (phase_next == cfg.interval) ? 8'd0 : phase_next;
            end
         end else begin
            if (name_length_ff >= MATCH_LEN || wanted_char(name_length_ff) != rx_byte) begin
               name_matches_in = 1'b0;
            end
            if (name_next == cfg.name_limit) begin
               name_length_in = 5'd0;
               in_name_in     = 1'b0;
            end else begin
               name_length_in = name_next;
            end
         end
      end
   end

   // parse state registers, advanced once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         after_newline_ff  <= 1'b0;
         in_name_ff        <= 1'b0;
         capturing_ff      <= 1'b0;
         name_length_ff    <= 5'd0;
         name_matches_ff   <= 1'b1;
         sentence_phase_ff <= 8'd0;
         body_length_ff    <= 8'd0;
      end else if (step) begin
         after_newline_ff  <= after_newline_in;
         in_name_ff        <= in_name_in;
         capturing_ff      <= capturing_in;
         name_length_ff    <= name_length_in;
         name_matches_ff   <= name_matches_in;
         sentence_phase_ff <= sentence_phase_in;
         body_length_ff    <= body_length_in;
      end
   end

endmodule

### hdl/nmea_sentence_selector.sv
// top level of the nmea sentence selector: registers, stages and handshakes
`timescale 1ns / 1ps

// Usage
//   req channel: one received serial byte per transaction (req_rx_byte),
//     taken at an edge with req_valid high and req_stall low.
//   rsp channel: zero or one transaction per byte: a body byte of a selected
//     GPRMC sentence, an end marker or an abort marker (rsp_kind, rsp_body_byte).
//   csr port: write-only; index 0 interval, 1 field limit, 2 name limit.
//     Write only while no byte is in flight.
// Path: a taken byte is held in the input register and parsed from there; its result
//   enters the output register when the byte advances, and is offered from then on.
// Throughput: one byte per cycle while req_stall stays low; the parse state update
//   for one byte is a single pass of compares and 8-bit and 5-bit increments between
//   the input register and the output register.
// Reset: clears all handshake and parse state and loads the register defaults
//   (interval 5, field limit 100, name limit 20).
// Stall: a held result keeps its values; the input register still drains
//   bytes that give no result, and req_stall rises only when a byte with a
//   result meets a full, stalled output register.
module nmea_sentence_selector (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_body_byte,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import nss_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;

   logic       has_result;
   rsp_type    result;
   logic       fire;

   // the parsed byte advances unless its result has nowhere to go
   assign fire      = in_valid_ff && (!has_result || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval    <= INTERVAL_RESET;
         cfg_ff.field_limit <= FIELD_LIMIT_RESET;
         cfg_ff.name_limit  <= NAME_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INTERVAL:    cfg_ff.interval    <= csr_wdata;
            CSR_FIELD_LIMIT: cfg_ff.field_limit <= csr_wdata;
            CSR_NAME_LIMIT:  cfg_ff.name_limit  <= csr_wdata[4:0];
            default:         ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   nss_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_body_byte = out_ff.body_byte;

endmodule

### hdl/nss_checker.sv
// port-level checks for the nmea sentence selector, bound to the top level
`timescale 1ns / 1ps

module nss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_body_byte
);
   import nss_pkg::*;

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // only the three defined kinds appear
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_BODY || rsp_kind == KIND_END ||
                     rsp_kind == KIND_ABORT))
      else $error("undefined result kind");

   // markers carry no byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BODY) |-> rsp_body_byte == 8'h00)
      else $error("marker with nonzero byte");

   // stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_body_byte)))
      else $error("stalled result changed");

endmodule

bind nmea_sentence_selector nss_checker u_nss_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_body_byte (rsp_body_byte)
);

### dv/nss_stream_checker.sv
// stream checker for the nmea sentence selector: tracks sentences and compares results
`timescale 1ns / 1ps

module nss_stream_checker
   import nss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_body_byte,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         pending_count
);

   localparam logic [39:0] RMC_NAME    = "GPRMC";
   localparam int          PRINT_LIMIT = 40;

   // local copies of the registers
   logic [7:0] rmc_interval;
   logic [7:0] body_limit;
   logic [4:0] hdr_limit;

   // sentence tracking state
   logic       line_armed;
   logic       in_header;
   logic       passing_body;
   logic       hdr_is_rmc;
   logic [4:0] hdr_len;
   logic [7:0] rmc_count;
   logic [7:0] body_count;

   // body bytes and markers still to come out of the block
   rsp_type capture_stream_q[$];

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [7:0] data);
      rsp_type r;
      r.kind      = kind;
      r.body_byte = data;
      capture_stream_q.push_back(r);
   endtask

   // advance the sentence tracker by one received byte
   task automatic track_nmea_byte(input logic [7:0] b);
      if (passing_body) begin
         if (b == CHAR_CR || b == CHAR_LF) begin
            // first terminator closes the capture
            passing_body = 1'b0;
            if (b == CHAR_LF) begin
               line_armed = 1'b1;
               in_header  = 1'b0;
            end
            push_result(KIND_END, 8'h00);
         end else begin
            body_count = body_count + 8'd1;
            if (body_count == body_limit) begin
               passing_body = 1'b0;
               body_count   = 8'd0;
               push_result(KIND_ABORT, 8'h00);
            end else begin
               push_result(KIND_BODY, b);
            end
         end
      end else if (b == CHAR_LF) begin
         line_armed = 1'b1;
         in_header  = 1'b0;
      end else if (line_armed) begin
         // only a start character right after a line feed opens a name
         if (b == CHAR_START) begin
            in_header  = 1'b1;
            hdr_len    = 5'd0;
            hdr_is_rmc = 1'b1;
         end
         line_armed = 1'b0;
      end else if (in_header) begin
         if (b == CHAR_SEP) begin
            in_header = 1'b0;
            if (hdr_is_rmc && hdr_len == MATCH_LEN) begin
               if (rmc_count == 8'd0) begin
                  passing_body = 1'b1;
                  body_count   = 8'd0;
               end
               rmc_count = rmc_count + 8'd1;
               if (rmc_count == rmc_interval)
                  rmc_count = 8'd0;
            end
         end else begin
            if (hdr_len >= MATCH_LEN)
               hdr_is_rmc = 1'b0;
            else if (RMC_NAME[8 * (4 - hdr_len) +: 8] != b)
               hdr_is_rmc = 1'b0;
            hdr_len = hdr_len + 5'd1;
            // garbled name: drop it until the next line feed
            if (hdr_len == hdr_limit) begin
               hdr_len   = 5'd0;
               in_header = 1'b0;
            end
         end
      end
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rmc_interval = INTERVAL_RESET;
         body_limit   = FIELD_LIMIT_RESET;
         hdr_limit    = NAME_LIMIT_RESET;
         line_armed   = 1'b0;
         in_header    = 1'b0;
         passing_body = 1'b0;
         hdr_is_rmc   = 1'b1;
         hdr_len      = 5'd0;
         rmc_count    = 8'd0;
         body_count   = 8'd0;
         capture_stream_q.delete();
      end else begin
         // result transaction against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (capture_stream_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                         rsp_kind, rsp_body_byte));
            end else begin
               want = capture_stream_q.pop_front();
               if (rsp_kind !== want.kind || rsp_body_byte !== want.body_byte)
                  report_mismatch($sformatf(
                     "result kind %0d byte %02h, expected kind %0d byte %02h",
                     rsp_kind, rsp_body_byte, want.kind, want.body_byte));
            end
         end
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_INTERVAL:    rmc_interval = csr_wdata;
               CSR_FIELD_LIMIT: body_limit   = csr_wdata;
               CSR_NAME_LIMIT:  hdr_limit    = csr_wdata[4:0];
               default: ;
            endcase
         end
         // input transaction
         if (req_valid && !req_stall)
            track_nmea_byte(req_rx_byte);
      end
      pending_count = capture_stream_q.size();
   end

endmodule

### dv/nmea_sentence_selector_tb.sv
// testbench top for the nmea sentence selector: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module nmea_sentence_selector_tb;
   import nss_pkg::*;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 8;
   localparam logic [1:0]  CSR_SPARE      = 2'd3;
   localparam logic [39:0] RMC_NAME       = "GPRMC";

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_body_byte;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   int fail_count;
   int pending_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int body_cap;
   int hdr_cap;
   int quiet_cycles = 0;

   logic [7:0] plan_q[$];

   always #5 clock = ~clock;

   nmea_sentence_selector u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_body_byte (rsp_body_byte),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   nss_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_body_byte (rsp_body_byte),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one byte transaction, entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_plan();
      foreach (plan_q[i]) send_byte(plan_q[i]);
      req_valid <= 1'b0;
      plan_q.delete();
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // wait for every result and for the pipeline to empty, then set the registers
   task automatic configure(input int interval, input int field, input int name);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(CSR_INTERVAL, 8'(interval));
      write_reg(CSR_FIELD_LIMIT, 8'(field));
      write_reg(CSR_NAME_LIMIT, {3'($urandom_range(7)), 5'(name)});
      write_reg(CSR_SPARE, 8'($urandom_range(255)));
      csr_write <= 1'b0;
      body_cap = (field == 0) ? 256 : field;
      hdr_cap  = (name == 0) ? 32 : name;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) plan_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] body_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (c == CHAR_CR || c == CHAR_LF) c = 8'($urandom_range(255));
      return c;
   endfunction

   task automatic push_body(input int len);
      for (int i = 0; i < len; i++) plan_q.push_back(body_char());
   endtask

   // one random piece of stream: half of the pieces are GPRMC sentences
   task automatic add_fragment();
      int         pick;
      int         len;
      int         tail;
      logic [7:0] c;
      pick = $urandom_range(99);
      if (pick < 50) begin
         plan_q.push_back(CHAR_LF);
         push_text("$GPRMC,");
         if ($urandom_range(99) < 15) begin
            if (body_cap > 62) len = $urandom_range(60, 64);
            else len = $urandom_range(body_cap - 2, body_cap + 2);
         end else begin
            len = $urandom_range(0, 12);
         end
         push_body(len);
         // CR LF, bare LF, lone CR, or run straight into the next piece
         tail = $urandom_range(99);
         if (tail < 90 && !(tail >= 55 && tail < 75)) plan_q.push_back(CHAR_CR);
         if (tail < 75) plan_q.push_back(CHAR_LF);
      end else if (pick < 65) begin
         // names close to the wanted one
         plan_q.push_back(CHAR_LF);
         plan_q.push_back(CHAR_START);
         len = $urandom_range(1, 7);
         for (int i = 0; i < len; i++) begin
            if (i < 5 && $urandom_range(3) != 0) c = RMC_NAME[8 * (4 - i) +: 8];
            else c = 8'($urandom_range(8'h41, 8'h5A));
            plan_q.push_back(c);
         end
         plan_q.push_back(CHAR_SEP);
         push_body($urandom_range(0, 6));
         plan_q.push_back(CHAR_CR);
         plan_q.push_back(CHAR_LF);
      end else if (pick < 75) begin
         // names around the length limit, carriage returns inside
         plan_q.push_back(CHAR_LF);
         plan_q.push_back(CHAR_START);
         len = hdr_cap + $urandom_range(0, 2) - $urandom_range(0, 2);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
               c = CHAR_CR;
            end else begin
               c = body_char();
               while (c == CHAR_SEP) c = body_char();
            end
            plan_q.push_back(c);
         end
         plan_q.push_back(CHAR_SEP);
         push_body($urandom_range(0, 4));
         plan_q.push_back(CHAR_LF);
      end else if (pick < 85) begin
         // start character not right after the line feed
         plan_q.push_back(CHAR_LF);
         c = body_char();
         while (c == CHAR_START) c = body_char();
         plan_q.push_back(c);
         push_text("$GPRMC,");
         push_body($urandom_range(0, 4));
         plan_q.push_back(CHAR_CR);
         plan_q.push_back(CHAR_LF);
      end else begin
         // noise rich in framing characters
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(5))
               0:       c = CHAR_LF;
               1:       c = CHAR_CR;
               2:       c = CHAR_START;
               3:       c = CHAR_SEP;
               4:       c = RMC_NAME[39:32];
               default: c = 8'($urandom_range(255));
            endcase
            plan_q.push_back(c);
         end
      end
   endtask

   task automatic run_phase(input int interval, input int field, input int name,
                            input int budget, input bit long_body);
      configure(interval, field, name);
      // a body long enough to wrap the length counter
      if (long_body) begin
         plan_q.push_back(CHAR_LF);
         push_text("$GPRMC,");
         push_body(260);
         plan_q.push_back(CHAR_LF);
      end
      while (plan_q.size() < budget) add_fragment();
      send_plan();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_write   = 1'b0;
      csr_index   = CSR_INTERVAL;
      csr_wdata   = 8'h00;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles less than receiver
      send_idle_pct = 29;
      recv_idle_pct = 70;

      // directed: byte extremes, end on CR then LF, abort at the body limit,
      // and a non-start byte after a line feed
      configure(1, 4, 7);
      plan_q.push_back(CHAR_LF);
      push_text("$GPRMC,");
      plan_q.push_back(8'h00);
      plan_q.push_back(8'hFF);
      plan_q.push_back(CHAR_CR);
      plan_q.push_back(CHAR_LF);
      push_text("$GPRMC,abcd");
      plan_q.push_back(CHAR_LF);
      push_text("X");
      send_plan();

      run_phase(1, 12, 7, 30, 1'b0);
      run_phase(1, 2, 31, 30, 1'b0);

      // receiver idles less than sender
      send_idle_pct = 70;
      recv_idle_pct = 29;
      run_phase(2, 0, 0, 70, 1'b1);
      run_phase(0, 40, 2, 20, 1'b0);

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(3, 255, 6, 30, 1'b0);
      run_phase(255, 20, 8, 30, 1'b0);

      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
